FILE: rtl/tptp_pkg.sv
// ----------------------------------------------------------------------------
// tptp_pkg: shared types and constants of the tracker pattern tick player
// Memory request bundle, sequencer states, opcode limits and period table.
// ----------------------------------------------------------------------------
`default_nettype none

package tptp_pkg;

   localparam int MEM_DEPTH = 65536;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   // item actions
   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_SAMPLES   = 3'd0;
   localparam logic [2:0] REG_ORNAMENTS = 3'd1;
   localparam logic [2:0] REG_PATTERNS  = 3'd2;
   localparam logic [2:0] REG_POS_START = 3'd3;
   localparam logic [2:0] REG_LOOP_POS  = 3'd4;

   // pattern opcode boundaries
   localparam logic [7:0] OP_NOTE_MAX  = 8'h5F;
   localparam logic [7:0] OP_PARAM_MAX = 8'h6E;
   localparam logic [7:0] OP_OFF       = 8'h6F;
   localparam logic [7:0] OP_OFFP_MAX  = 8'h7F;
   localparam logic [7:0] OP_SHIFT_MAX = 8'h9F;
   localparam logic [7:0] OP_REP_MAX   = 8'hBF;
   localparam logic [7:0] OP_PARAM_BASE = 8'h60;
   localparam logic [7:0] NOTE_MAX     = 8'h5F;
   localparam logic [7:0] LOOP_MARK    = 8'd32;
   localparam logic [7:0] TICKS_INIT   = 8'd32;
   localparam logic [3:0] TRANSPOSE_NEG = 4'd9;

   // parameter command codes (operand minus one)
   localparam logic [7:0] K_VOL_SET     = 8'd0;
   localparam logic [7:0] K_VOL_ADD     = 8'd1;
   localparam logic [7:0] K_VOL_ALL     = 8'd2;
   localparam logic [7:0] K_VOL_ALL_ADD = 8'd3;
   localparam logic [7:0] K_SPEED_SET   = 8'd4;
   localparam logic [7:0] K_SPEED_ADD   = 8'd5;
   localparam logic [7:0] K_GLIDE_DOWN  = 8'd6;
   localparam logic [7:0] K_GLIDE_UP    = 8'd7;

   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic [MEM_AW-1:0] raddr;
   } mem_req_type;

   typedef enum logic [5:0] {
      S_IDLE, S_RD, S_TICK,
      S_L0, S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7, S_L8,
      S_I0, S_I1, S_P0, S_P1,
      S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_TEND,
      S_SS0, S_SS1, S_SS2, S_OS0, S_OS1, S_OS2,
      S_RP0, S_RP1, S_CHN,
      S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_C10, S_C11,
      S_CRN, S_OUT
   } state_type;

   function automatic logic [11:0] period_lookup(input logic [6:0] idx);
      logic [11:0] r;
      unique case (idx)
         7'd0: r = 12'hD5D;  7'd1: r = 12'hC9C;  7'd2: r = 12'hBE7;  7'd3: r = 12'hB3C;
         7'd4: r = 12'hA9B;  7'd5: r = 12'hA02;  7'd6: r = 12'h973;  7'd7: r = 12'h8EB;
         7'd8: r = 12'h86B;  7'd9: r = 12'h7F2;  7'd10: r = 12'h780; 7'd11: r = 12'h714;
         7'd12: r = 12'h6AE; 7'd13: r = 12'h64E; 7'd14: r = 12'h5F4; 7'd15: r = 12'h59E;
         7'd16: r = 12'h54F; 7'd17: r = 12'h501; 7'd18: r = 12'h4B9; 7'd19: r = 12'h475;
         7'd20: r = 12'h435; 7'd21: r = 12'h3F9; 7'd22: r = 12'h3C0; 7'd23: r = 12'h38A;
         7'd24: r = 12'h357; 7'd25: r = 12'h327; 7'd26: r = 12'h2FA; 7'd27: r = 12'h2CF;
         7'd28: r = 12'h2A7; 7'd29: r = 12'h281; 7'd30: r = 12'h25D; 7'd31: r = 12'h23B;
         7'd32: r = 12'h21B; 7'd33: r = 12'h1FC; 7'd34: r = 12'h1E0; 7'd35: r = 12'h1C5;
         7'd36: r = 12'h1AC; 7'd37: r = 12'h194; 7'd38: r = 12'h17D; 7'd39: r = 12'h168;
         7'd40: r = 12'h153; 7'd41: r = 12'h140; 7'd42: r = 12'h12E; 7'd43: r = 12'h11D;
         7'd44: r = 12'h10D; 7'd45: r = 12'h0FE; 7'd46: r = 12'h0F0; 7'd47: r = 12'h0E2;
         7'd48: r = 12'h0D6; 7'd49: r = 12'h0CA; 7'd50: r = 12'h0BE; 7'd51: r = 12'h0B4;
         7'd52: r = 12'h0AA; 7'd53: r = 12'h0A0; 7'd54: r = 12'h097; 7'd55: r = 12'h08F;
         7'd56: r = 12'h087; 7'd57: r = 12'h07F; 7'd58: r = 12'h078; 7'd59: r = 12'h071;
         7'd60: r = 12'h06B; 7'd61: r = 12'h065; 7'd62: r = 12'h05F; 7'd63: r = 12'h05A;
         7'd64: r = 12'h055; 7'd65: r = 12'h050; 7'd66: r = 12'h04C; 7'd67: r = 12'h047;
         7'd68: r = 12'h043; 7'd69: r = 12'h040; 7'd70: r = 12'h03C; 7'd71: r = 12'h039;
         7'd72: r = 12'h035; 7'd73: r = 12'h032; 7'd74: r = 12'h030; 7'd75: r = 12'h02D;
         7'd76: r = 12'h02A; 7'd77: r = 12'h028; 7'd78: r = 12'h026; 7'd79: r = 12'h024;
         7'd80: r = 12'h022; 7'd81: r = 12'h020; 7'd82: r = 12'h01E; 7'd83: r = 12'h01C;
         7'd84: r = 12'h01B; 7'd85: r = 12'h019; 7'd86: r = 12'h018; 7'd87: r = 12'h016;
         7'd88: r = 12'h015; 7'd89: r = 12'h014; 7'd90: r = 12'h013; 7'd91: r = 12'h012;
         7'd92: r = 12'h011; 7'd93: r = 12'h010; 7'd94: r = 12'h00F; 7'd95: r = 12'h00E;
         default: r = 12'h00E;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/tptp_mem.sv
// ----------------------------------------------------------------------------
// tptp_mem: module image byte memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tptp_mem (
   input  wire                   clock,
   input  tptp_pkg::mem_req_type mem_req,
   output logic [7:0]            rdata
);
   import tptp_pkg::*;

   logic [7:0] mem [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata <= mem[mem_req.raddr];
   end

endmodule

`default_nettype wire

FILE: rtl/tracker_pattern_tick_player.sv
// ----------------------------------------------------------------------------
// tracker_pattern_tick_player: three-channel tracker pattern player
// A sequencer walks the position list, pattern commands, samples and
// ornaments through one byte read port and emits sound chip register values.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  request   req_action/mem_addr/mem_byte start high while busy low
//  result    rsp_*                        rsp_valid high one cycle per tick
//  config    psel/penable/pwrite/paddr    APB, pready tied high
//
//  Write and restart items leave the sequencer idle. A tick runs the
//  sequencer, and every module memory read waits in S_RD on the single
//  registered read port; a line boundary reads the position list.
//  Reset is synchronous; the memory is not cleared. The result beat cannot
//  be stalled and is shown the cycle after the sequencer finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module tracker_pattern_tick_player (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_action,
   input  wire  [15:0] req_mem_addr,
   input  wire  [7:0]  req_mem_byte,
   output logic        rsp_valid,
   output logic [11:0] rsp_tone_a,
   output logic [11:0] rsp_tone_b,
   output logic [11:0] rsp_tone_c,
   output logic [4:0]  rsp_noise_period,
   output logic [5:0]  rsp_mixer,
   output logic [4:0]  rsp_amp_a,
   output logic [4:0]  rsp_amp_b,
   output logic [4:0]  rsp_amp_c,
   output logic [3:0]  rsp_env_shape,
   output logic [7:0]  rsp_env_period_fine,
   output logic        rsp_env_shape_written,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [4:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tptp_pkg::*;

   // configuration
   logic [15:0] smp_base_ff, orn_base_ff, pat_base_ff, pos_start_ff, loop_pos_ff;

   // sequencer
   state_type   state_ff, state_in, ret_ff, ret_in, cont_ff, cont_in;
   logic [15:0] rda_ff, rda_in;
   logic [1:0]  c_ff, c_in;
   logic        first_ff, first_in;
   logic [15:0] p_ff, p_in, src_ff, src_in;
   logic [7:0]  op_ff, op_in, arg_ff, arg_in, k_ff, k_in, lo_ff, lo_in;
   logic [7:0]  tmp_ff, tmp_in, b0_ff, b0_in, b1_ff, b1_in, j_ff, j_in;
   logic [11:0] ton_ff, ton_in;
   logic [5:0]  mix_ff, mix_in, mixout_ff, mixout_in;
   logic [4:0]  amp_ff [3], amp_in [3];
   logic        valid_ff, valid_in;

   // playback state
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  spd_ff, spd_in, spdv_ff, spdv_in, line_ff, line_in;
   logic [4:0]  noise_ff, noise_in;
   logic [11:0] env_ff, env_in;
   logic        envw_ff, envw_in;
   logic [15:0] pat_ff [3], pat_in [3], cmd_ff [3], cmd_in [3];
   logic [3:0]  rep_ff [3], rep_in [3], tr_ff [3], tr_in [3];
   logic [2:0]  on_ff, on_in, mn_ff, mn_in, mt_ff, mt_in, gl_ff, gl_in;
   logic [2:0]  eon_ff, eon_in, oon_ff, oon_in, vc_ff, vc_in, fr_ff, fr_in;
   logic [2:0]  ra_ff, ra_in;
   logic [7:0]  note_ff [3], note_in [3], vol_ff [3], vol_in [3];
   logic [15:0] sst_ff [3], sst_in [3], spos_ff [3], spos_in [3];
   logic [15:0] ost_ff [3], ost_in [3], opos_ff [3], opos_in [3];
   logic [7:0]  stk_ff [3], stk_in [3], otk_ff [3], otk_in [3];
   logic [15:0] goff_ff [3], goff_in [3], gstep_ff [3], gstep_in [3];
   logic [11:0] tone_ff [3], tone_in [3];

   logic [7:0]  q;
   logic        accept, clr, cfg_wr;
   mem_req_type mem_req;

   assign accept = start && !busy;
   assign clr    = accept && (req_action == ACT_RESTART);
   assign cfg_wr = psel && penable && pwrite && pready;
   assign busy   = (state_ff != S_IDLE);
   assign pready = 1'b1;

   always_comb begin
      mem_req.we    = accept && (req_action == ACT_WRITE);
      mem_req.waddr = req_mem_addr[MEM_AW-1:0];
      mem_req.wdata = req_mem_byte;
      mem_req.raddr = rda_ff[MEM_AW-1:0];
   end

   tptp_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (q)
   );

   always_comb begin
      unique case (paddr[4:2])
         REG_SAMPLES:   prdata = {16'd0, smp_base_ff};
         REG_ORNAMENTS: prdata = {16'd0, orn_base_ff};
         REG_PATTERNS:  prdata = {16'd0, pat_base_ff};
         REG_POS_START: prdata = {16'd0, pos_start_ff};
         REG_LOOP_POS:  prdata = {16'd0, loop_pos_ff};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_base_ff  <= 16'd0;
         orn_base_ff  <= 16'd0;
         pat_base_ff  <= 16'd0;
         pos_start_ff <= 16'd0;
         loop_pos_ff  <= 16'd0;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            REG_SAMPLES:   smp_base_ff  <= pwdata[15:0];
            REG_ORNAMENTS: orn_base_ff  <= pwdata[15:0];
            REG_PATTERNS:  pat_base_ff  <= pwdata[15:0];
            REG_POS_START: pos_start_ff <= pwdata[15:0];
            REG_LOOP_POS:  loop_pos_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      logic [7:0] o_dec;
      o_dec    = 8'd0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept && req_action == ACT_TICK) state_in = S_TICK;
         S_RD:   state_in = ret_ff;
         S_TICK: begin
            if (spd_ff != 8'd1)       state_in = S_C0;
            else if (line_ff != 8'd1) state_in = S_I0;
            else                      state_in = S_L0;
         end
         S_L1:   state_in = (q == 8'd0) ? S_RD : S_L2;
         S_L4:   state_in = first_ff ? S_RD : S_L6;
         S_L5:   state_in = S_L6;
         S_L7:   state_in = (c_ff == 2'd0) ? S_RD : S_L0;
         S_L8:   state_in = S_I0;
         S_I0: begin
            if (rep_ff[c_ff] != 4'd0) state_in = ra_ff[c_ff] ? S_RP0 : S_CHN;
            else                      state_in = S_RD;
         end
         S_I1: begin
            if (q <= OP_NOTE_MAX)       state_in = S_T0;
            else if (q <= OP_PARAM_MAX) state_in = S_P0;
            else if (q <= OP_OFFP_MAX)  state_in = (q != OP_OFF) ? S_P0 : S_CHN;
            else if (q <= OP_REP_MAX)
               state_in = (q <= OP_SHIFT_MAX || q[4]) ? S_RP0 : S_CHN;
            else                        state_in = S_SS0;
         end
         S_P1:   state_in = cont_ff;
         S_T1: begin
            if (q <= OP_OFFP_MAX)    state_in = S_P0;
            else if (q[5:1] != 5'd0) state_in = S_SS0;
            else                     state_in = S_T2;
         end
         S_T2:   state_in = op_ff[6] ? S_RD : S_TEND;
         S_T3: begin
            o_dec    = {3'd0, op_ff[0], q[7:4]};
            state_in = (o_dec != 8'd0) ? S_OS0 : S_T4;
         end
         S_T5:   state_in = (q[3:0] != 4'd0) ? S_P0 : S_TEND;
         S_TEND: state_in = S_CHN;
         S_SS2, S_OS2: state_in = cont_ff;
         S_RP1:  state_in = (q <= OP_OFFP_MAX) ? S_T0 : S_SS0;
         S_CHN:  state_in = (c_ff != 2'd0) ? S_I0 : S_C0;
         S_C0:   state_in = on_ff[c_ff] ? S_RD : S_CRN;
         S_C2:   state_in = oon_ff[c_ff] ? S_RD : S_C7;
         S_C3:   state_in = (otk_ff[c_ff] == 8'd1) ? S_RD : S_C7;
         S_C6:   state_in = S_C7;
         S_C8:   state_in = (stk_ff[c_ff] == 8'd1) ? S_RD : S_C11;
         S_C10:  state_in = S_C11;
         S_C11:  state_in = S_CRN;
         S_CRN:  state_in = (c_ff != 2'd0) ? S_C0 : S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_RD;   // every other state issues a memory read
      endcase
   end

   // datapath
   always_comb begin
      logic [15:0] pn, w;
      logic [7:0]  a8, v8, jj, tr8;
      logic [11:0] per, delta, t12;
      pn = 16'd0; w = 16'd0; a8 = 8'd0; v8 = 8'd0; jj = 8'd0; tr8 = 8'd0;
      per = 12'd0; delta = 12'd0; t12 = 12'd0;

      ret_in = ret_ff;   cont_in = cont_ff;  rda_in = rda_ff;  c_in = c_ff;
      first_in = first_ff; p_in = p_ff; src_in = src_ff; op_in = op_ff;
      arg_in = arg_ff; k_in = k_ff; lo_in = lo_ff; tmp_in = tmp_ff;
      b0_in = b0_ff; b1_in = b1_ff; j_in = j_ff; ton_in = ton_ff;
      mix_in = mix_ff; mixout_in = mixout_ff; amp_in = amp_ff;
      valid_in = (state_ff == S_OUT);
      pos_in = pos_ff; spd_in = spd_ff; spdv_in = spdv_ff; line_in = line_ff;
      noise_in = noise_ff; env_in = env_ff; envw_in = envw_ff;
      pat_in = pat_ff; cmd_in = cmd_ff; rep_in = rep_ff; tr_in = tr_ff;
      on_in = on_ff; mn_in = mn_ff; mt_in = mt_ff; gl_in = gl_ff;
      eon_in = eon_ff; oon_in = oon_ff; vc_in = vc_ff; fr_in = fr_ff; ra_in = ra_ff;
      note_in = note_ff; vol_in = vol_ff; sst_in = sst_ff; spos_in = spos_ff;
      ost_in = ost_ff; opos_in = opos_ff; stk_in = stk_ff; otk_in = otk_ff;
      goff_in = goff_ff; gstep_in = gstep_ff; tone_in = tone_ff;

      case (state_ff)
         S_TICK: begin
            envw_in = 1'b0;
            c_in    = 2'd2;
            mix_in  = 6'd0;
            first_in = 1'b1;
            if (spd_ff != 8'd1) begin
               spd_in = spd_ff - 8'd1;
            end else begin
               spd_in  = spdv_ff;
               line_in = line_ff - 8'd1;
            end
         end
         // position list
         S_L0: begin rda_in = pos_ff; ret_in = S_L1; end
         S_L1: begin
            if (q == 8'd0) begin
               pos_in = loop_pos_ff;
               rda_in = loop_pos_ff;
               ret_in = S_L2;
            end
         end
         S_L2: begin
            vc_in[c_ff] = q[7];
            rda_in = pat_base_ff + {8'd0, q[6:0], 1'b0};
            ret_in = S_L3;
         end
         S_L3: begin lo_in = q; rda_in = rda_ff + 16'd1; ret_in = S_L4; end
         S_L4: begin
            p_in = {q, lo_ff};
            if (first_ff) begin rda_in = {q, lo_ff}; ret_in = S_L5; end
         end
         S_L5: line_in = q;
         S_L6: begin
            pat_in[c_ff] = p_ff + 16'd1;
            pos_in = pos_ff + 16'd1;
            rda_in = pos_ff + 16'd1;
            ret_in = S_L7;
         end
         S_L7: begin
            vol_in[c_ff] = {4'd0, q[3:0]};
            tr_in[c_ff]  = q[7:4];
            pos_in       = pos_ff + 16'd1;
            rep_in[c_ff] = 4'd0;
            first_in     = 1'b0;
            if (c_ff == 2'd0) begin
               rda_in = pos_ff + 16'd1;
               ret_in = S_L8;
            end else begin
               c_in = c_ff - 2'd1;
            end
         end
         S_L8: begin
            spdv_in = q;
            spd_in  = q;
            pos_in  = pos_ff + 16'd1;
            c_in    = 2'd2;
         end
         // pattern interpreter
         S_I0: begin
            if (rep_ff[c_ff] != 4'd0) begin
               rep_in[c_ff] = rep_ff[c_ff] - 4'd1;
            end else begin
               p_in = pat_ff[c_ff];
               fr_in[c_ff] = 1'b1;
               ra_in[c_ff] = 1'b0;
               rda_in = pat_ff[c_ff];
               ret_in = S_I1;
            end
         end
         S_I1: begin
            op_in = q;
            if (q <= OP_NOTE_MAX) begin
               note_in[c_ff] = q;
               cmd_in[c_ff]  = p_ff;
               p_in          = p_ff + 16'd1;
            end else if (q <= OP_PARAM_MAX) begin
               arg_in  = q - OP_PARAM_BASE;
               cont_in = S_CHN;
            end else if (q <= OP_OFFP_MAX) begin
               mn_in[c_ff] = 1'b0;
               mt_in[c_ff] = 1'b0;
               on_in[c_ff] = 1'b0;
               if (q != OP_OFF) begin
                  arg_in  = q - OP_OFF;
                  cont_in = S_CHN;
               end else begin
                  pat_in[c_ff] = p_ff + 16'd1;
               end
            end else if (q <= OP_REP_MAX) begin
               pat_in[c_ff] = p_ff + 16'd1;
               if (q <= OP_SHIFT_MAX) begin
                  if (!q[4]) note_in[c_ff] = note_ff[c_ff] + {4'd0, q[3:0]};
                  else       note_in[c_ff] = note_ff[c_ff] - {4'd0, q[3:0]};
               end else begin
                  rep_in[c_ff] = q[3:0];
                  if (q[4] && q[3:0] != 4'd0) ra_in[c_ff] = 1'b1;
               end
            end else begin
               pat_in[c_ff] = p_ff + 16'd1;
               cmd_in[c_ff] = p_ff;
               arg_in  = {3'd0, q[4:0]};
               cont_in = S_CHN;
            end
         end
         // parameter command
         S_P0: begin
            k_in = arg_ff - 8'd1;
            pn   = p_ff + 16'd1;
            p_in = pn;
            if (fr_ff[c_ff]) begin
               pat_in[c_ff] = pn + 16'd1;
               fr_in[c_ff]  = 1'b0;
            end
            rda_in = pn;
            ret_in = S_P1;
         end
         S_P1: begin
            case (k_ff)
               K_VOL_SET: if (vc_ff[c_ff]) vol_in[c_ff] = {4'd0, q[3:0]};
               K_VOL_ADD: begin
                  v8 = vol_ff[c_ff] + q;
                  if (vc_ff[c_ff]) vol_in[c_ff] = {4'd0, v8[3:0]};
               end
               K_VOL_ALL: begin
                  if (vc_ff[c_ff]) for (int i = 0; i < 3; i++) vol_in[i] = q;
               end
               K_VOL_ALL_ADD: begin
                  if (vc_ff[c_ff]) begin
                     for (int i = 0; i < 3; i++) begin
                        vol_in[i] = {4'd0, vol_ff[i][3:0] + q[3:0]};
                     end
                  end
               end
               K_SPEED_SET, K_SPEED_ADD: begin
                  v8 = (k_ff == K_SPEED_SET) ? {3'd0, q[4:0]}
                                             : {3'd0, spd_ff[4:0] + q[4:0]};
                  if (v8 == 8'd0) v8 = TICKS_INIT;
                  if (vc_ff[c_ff]) begin
                     spd_in  = v8;
                     spdv_in = v8;
                  end
               end
               K_GLIDE_DOWN, K_GLIDE_UP: begin
                  goff_in[c_ff]  = 16'd0;
                  gl_in[c_ff]    = 1'b1;
                  gstep_in[c_ff] = (k_ff == K_GLIDE_DOWN) ? (16'd0 - {8'd0, q})
                                                          : {8'd0, q};
               end
               default: begin
                  eon_in[c_ff] = 1'b1;
                  env_in       = {k_ff[3:0], q};
                  envw_in      = 1'b1;
               end
            endcase
         end
         // note tail
         S_T0: begin rda_in = p_ff; ret_in = S_T1; end
         S_T1: begin
            op_in = q;
            if (q <= OP_OFFP_MAX) begin
               arg_in  = q;
               cont_in = S_TEND;
            end else if (q[5:1] != 5'd0) begin
               arg_in  = {3'd0, q[5:1]};
               cont_in = S_T2;
            end
         end
         S_T2: if (op_ff[6]) begin rda_in = p_ff + 16'd1; ret_in = S_T3; end
         S_T3: begin
            arg_in  = {3'd0, op_ff[0], q[7:4]};
            cont_in = S_T4;
         end
         S_T4: begin
            p_in   = p_ff + 16'd1;
            rda_in = p_ff + 16'd1;
            ret_in = S_T5;
         end
         S_T5: begin
            arg_in  = {4'd0, q[3:0]};
            cont_in = S_TEND;
         end
         S_TEND: begin
            pn   = p_ff + 16'd1;
            p_in = pn;
            if (fr_ff[c_ff]) pat_in[c_ff] = pn;
         end
         // sample and ornament selection
         S_SS0: begin
            eon_in[c_ff] = 1'b0;
            oon_in[c_ff] = 1'b0;
            gl_in[c_ff]  = 1'b0;
            on_in[c_ff]  = 1'b1;
            mn_in[c_ff]  = 1'b1;
            mt_in[c_ff]  = 1'b1;
            rda_in = smp_base_ff + {7'd0, arg_ff, 1'b0};
            ret_in = S_SS1;
         end
         S_SS1, S_OS1: begin
            lo_in  = q;
            rda_in = rda_ff + 16'd1;
            ret_in = (state_ff == S_SS1) ? S_SS2 : S_OS2;
         end
         S_SS2: begin
            w = {q, lo_ff};
            sst_in[c_ff]  = w;
            spos_in[c_ff] = w + 16'd2;
            stk_in[c_ff]  = TICKS_INIT;
         end
         S_OS0: begin
            rda_in = orn_base_ff + {7'd0, arg_ff, 1'b0};
            ret_in = S_OS1;
         end
         S_OS2: begin
            w = {q, lo_ff};
            ost_in[c_ff]  = w;
            opos_in[c_ff] = w + 16'd2;
            otk_in[c_ff]  = TICKS_INIT;
            oon_in[c_ff]  = 1'b1;
         end
         // replay of the last note command
         S_RP0: begin
            p_in = cmd_ff[c_ff];
            fr_in[c_ff] = 1'b0;
            rda_in = cmd_ff[c_ff];
            ret_in = S_RP1;
         end
         S_RP1: begin
            if (q <= OP_OFFP_MAX) begin
               p_in = p_ff + 16'd1;
            end else begin
               arg_in  = {3'd0, q[4:0]};
               cont_in = S_CHN;
            end
         end
         S_CHN: begin
            if (c_ff != 2'd0) begin
               c_in = c_ff - 2'd1;
            end else begin
               c_in   = 2'd2;
               mix_in = 6'd0;
            end
         end
         // channel registers
         S_C0: begin
            mix_in = {mix_ff[4:0], 1'b0};
            if (!on_ff[c_ff]) begin
               amp_in[c_ff] = 5'd0;
            end else begin
               rda_in = spos_ff[c_ff];
               ret_in = S_C1;
            end
         end
         S_C1: begin
            b0_in = q;
            a8 = {4'd0, q[3:0]};
            if (a8 != 8'd0) begin
               a8 = a8 - vol_ff[c_ff];
               if (a8[7]) a8 = 8'd0;
            end else if (eon_ff[c_ff]) begin
               a8 = 8'd16;
            end
            amp_in[c_ff] = a8[4:0];
            rda_in = spos_ff[c_ff] + 16'd1;
            ret_in = S_C2;
         end
         S_C2: begin
            b1_in = q;
            if (q[5]) begin
               mix_in[3] = 1'b1;
               noise_in  = {b0_ff[7:4], 1'b0} + {4'd0, q[7]};
            end
            if (q[6]) mix_in[0] = 1'b1;
            j_in = note_ff[c_ff];
            if (oon_ff[c_ff]) begin
               rda_in = opos_ff[c_ff];
               ret_in = S_C3;
            end
         end
         S_C3: begin
            j_in = j_ff + q;
            otk_in[c_ff] = otk_ff[c_ff] - 8'd1;
            if (otk_ff[c_ff] == 8'd1) begin
               rda_in = ost_ff[c_ff];
               ret_in = S_C4;
            end else begin
               opos_in[c_ff] = opos_ff[c_ff] + 16'd1;
            end
         end
         S_C4: begin
            // a looping ornament borrows its loop point from the sample
            src_in = (q != LOOP_MARK) ? ost_ff[c_ff] : sst_ff[c_ff];
            rda_in = (q != LOOP_MARK) ? ost_ff[c_ff] : sst_ff[c_ff];
            ret_in = S_C5;
         end
         S_C5: begin tmp_in = q; rda_in = src_ff + 16'd1; ret_in = S_C6; end
         S_C6: begin
            otk_in[c_ff]  = q;
            opos_in[c_ff] = ost_ff[c_ff] + 16'd2 + {8'd0, tmp_ff};
         end
         S_C7: begin
            tr8 = (tr_ff[c_ff] < TRANSPOSE_NEG) ? {4'd0, tr_ff[c_ff]}
                                                : (8'd8 - {4'd0, tr_ff[c_ff]});
            jj = j_ff + tr8;
            if (jj > NOTE_MAX) jj = NOTE_MAX;
            j_in   = jj;
            rda_in = spos_ff[c_ff] + 16'd2;
            ret_in = S_C8;
         end
         S_C8: begin
            per   = period_lookup(j_ff[6:0]);
            delta = {b1_ff[3:0], q};
            ton_in = b1_ff[4] ? (per + delta) : (per - delta);
            stk_in[c_ff] = stk_ff[c_ff] - 8'd1;
            if (stk_ff[c_ff] == 8'd1) begin
               rda_in = sst_ff[c_ff] + 16'd1;
               ret_in = S_C9;
            end else begin
               spos_in[c_ff] = spos_ff[c_ff] + 16'd3;
            end
         end
         S_C9: begin stk_in[c_ff] = q; rda_in = sst_ff[c_ff]; ret_in = S_C10; end
         S_C10: begin
            if (q == LOOP_MARK) begin
               on_in[c_ff]  = 1'b0;
               oon_in[c_ff] = 1'b0;
            end
            spos_in[c_ff] = sst_ff[c_ff] + 16'd2 + {7'd0, q, 1'b0} + {8'd0, q};
         end
         S_C11: begin
            t12 = ton_ff;
            if (gl_ff[c_ff]) begin
               t12 = ton_ff + goff_ff[c_ff][11:0];
               goff_in[c_ff] = goff_ff[c_ff] + gstep_ff[c_ff];
            end
            tone_in[c_ff] = t12;
         end
         S_CRN: if (c_ff != 2'd0) c_in = c_ff - 2'd1;
         S_OUT: begin
            mixout_in = ~mix_ff;
            if (!mn_ff[0]) mixout_in[3] = 1'b1;
            if (!mt_ff[0]) mixout_in[0] = 1'b1;
            if (!mn_ff[1]) mixout_in[4] = 1'b1;
            if (!mt_ff[1]) mixout_in[1] = 1'b1;
            if (!mn_ff[2]) mixout_in[5] = 1'b1;
            if (!mt_ff[2]) mixout_in[2] = 1'b1;
         end
         default: ;
      endcase
   end

   // control and temporaries
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      ret_ff <= ret_in;   cont_ff <= cont_in; rda_ff <= rda_in; c_ff <= c_in;
      first_ff <= first_in; p_ff <= p_in; src_ff <= src_in; op_ff <= op_in;
      arg_ff <= arg_in; k_ff <= k_in; lo_ff <= lo_in; tmp_ff <= tmp_in;
      b0_ff <= b0_in; b1_ff <= b1_in; j_ff <= j_in; ton_ff <= ton_in;
      mix_ff <= mix_in; mixout_ff <= mixout_in; amp_ff <= amp_in;
   end

   // playback state: cleared by reset and by a restart beat
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         pos_ff <= pos_start_ff;
         spd_ff <= 8'd1; spdv_ff <= 8'd1; line_ff <= 8'd1;
         noise_ff <= 5'd0; env_ff <= 12'd0; envw_ff <= 1'b0;
         on_ff <= 3'd0; mn_ff <= 3'd0; mt_ff <= 3'd0; gl_ff <= 3'd0;
         eon_ff <= 3'd0; oon_ff <= 3'd0; vc_ff <= 3'd0; fr_ff <= 3'd0; ra_ff <= 3'd0;
         for (int i = 0; i < 3; i++) begin
            pat_ff[i] <= 16'd0;  cmd_ff[i] <= 16'd0;  rep_ff[i] <= 4'd0;
            tr_ff[i] <= 4'd0;    note_ff[i] <= 8'd0;  vol_ff[i] <= 8'd0;
            sst_ff[i] <= 16'd0;  spos_ff[i] <= 16'd0; ost_ff[i] <= 16'd0;
            opos_ff[i] <= 16'd0; stk_ff[i] <= 8'd0;   otk_ff[i] <= 8'd0;
            goff_ff[i] <= 16'd0; gstep_ff[i] <= 16'd0; tone_ff[i] <= 12'd0;
         end
         if (reset) pos_ff <= 16'd0;
      end else begin
         pos_ff <= pos_in; spd_ff <= spd_in; spdv_ff <= spdv_in; line_ff <= line_in;
         noise_ff <= noise_in; env_ff <= env_in; envw_ff <= envw_in;
         on_ff <= on_in; mn_ff <= mn_in; mt_ff <= mt_in; gl_ff <= gl_in;
         eon_ff <= eon_in; oon_ff <= oon_in; vc_ff <= vc_in; fr_ff <= fr_in;
         ra_ff <= ra_in;
         pat_ff <= pat_in;   cmd_ff <= cmd_in;   rep_ff <= rep_in;  tr_ff <= tr_in;
         note_ff <= note_in; vol_ff <= vol_in;   sst_ff <= sst_in;  spos_ff <= spos_in;
         ost_ff <= ost_in;   opos_ff <= opos_in; stk_ff <= stk_in;  otk_ff <= otk_in;
         goff_ff <= goff_in; gstep_ff <= gstep_in; tone_ff <= tone_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_tone_a            = tone_ff[0];
   assign rsp_tone_b            = tone_ff[1];
   assign rsp_tone_c            = tone_ff[2];
   assign rsp_noise_period      = noise_ff;
   assign rsp_mixer             = mixout_ff;
   assign rsp_amp_a             = amp_ff[0];
   assign rsp_amp_b             = amp_ff[1];
   assign rsp_amp_c             = amp_ff[2];
   assign rsp_env_shape         = env_ff[11:8];
   assign rsp_env_period_fine   = env_ff[7:0];
   assign rsp_env_shape_written = envw_ff;

endmodule

`default_nettype wire

FILE: tb/sv/tracker_pattern_tick_player_test.sv
// ----------------------------------------------------------------------------
// tracker_pattern_tick_player_test: self-checking bench for the tick player
// Fills the whole module memory, then loads several random songs under
// different table bases and plays them with ticks, restarts and stray writes.
// A scoreboard predicts every tick's register frame and checks each result.
// ----------------------------------------------------------------------------
module tracker_pattern_tick_player_test import tptp_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 400;
   localparam bit [1:0] ACT_UNUSED = 2'd3;

   localparam bit [11:0] NOTE_PERIOD [96] = '{
      12'hD5D, 12'hC9C, 12'hBE7, 12'hB3C, 12'hA9B, 12'hA02, 12'h973, 12'h8EB,
      12'h86B, 12'h7F2, 12'h780, 12'h714, 12'h6AE, 12'h64E, 12'h5F4, 12'h59E,
      12'h54F, 12'h501, 12'h4B9, 12'h475, 12'h435, 12'h3F9, 12'h3C0, 12'h38A,
      12'h357, 12'h327, 12'h2FA, 12'h2CF, 12'h2A7, 12'h281, 12'h25D, 12'h23B,
      12'h21B, 12'h1FC, 12'h1E0, 12'h1C5, 12'h1AC, 12'h194, 12'h17D, 12'h168,
      12'h153, 12'h140, 12'h12E, 12'h11D, 12'h10D, 12'h0FE, 12'h0F0, 12'h0E2,
      12'h0D6, 12'h0CA, 12'h0BE, 12'h0B4, 12'h0AA, 12'h0A0, 12'h097, 12'h08F,
      12'h087, 12'h07F, 12'h078, 12'h071, 12'h06B, 12'h065, 12'h05F, 12'h05A,
      12'h055, 12'h050, 12'h04C, 12'h047, 12'h043, 12'h040, 12'h03C, 12'h039,
      12'h035, 12'h032, 12'h030, 12'h02D, 12'h02A, 12'h028, 12'h026, 12'h024,
      12'h022, 12'h020, 12'h01E, 12'h01C, 12'h01B, 12'h019, 12'h018, 12'h016,
      12'h015, 12'h014, 12'h013, 12'h012, 12'h011, 12'h010, 12'h00F, 12'h00E};

   typedef struct packed {
      bit [15:0] pat_addr, cmd_addr;
      bit [7:0]  rep;
      bit        on, mix_noise, mix_tone, glide, env_on, orn_on;
      bit        vol_cmds, fresh, rep_active;
      bit [7:0]  note, vol, transp;
      bit [15:0] smp_start, smp_pos;
      bit [7:0]  smp_ticks;
      bit [15:0] orn_start, orn_pos;
      bit [7:0]  orn_ticks;
      bit [15:0] gl_off, gl_step, tone;
   } voice_t;

   typedef struct packed {
      bit [11:0] tone_a, tone_b, tone_c;
      bit [4:0]  noise;
      bit [5:0]  mixer;
      bit [4:0]  amp_a, amp_b, amp_c;
      bit [3:0]  env_shape;
      bit [7:0]  env_fine;
      bit        env_wr;
   } frame_t;

   class tick_scoreboard;
      bit [7:0]  mem [MEM_DEPTH];
      bit [15:0] smp_base, orn_base, pat_base, pos_start, loop_pos;
      bit [15:0] pos_addr;
      bit [7:0]  speed_cd, speed_val, line_cd;
      voice_t    ch [3];
      bit [4:0]  noise;
      bit [11:0] env;
      bit        env_wr;
      frame_t    frames [$];
      int        errors;

      function new();
         smp_base = 0; orn_base = 0; pat_base = 0; pos_start = 0; loop_pos = 0;
         errors = 0;
         rewind();
      endfunction

      function void rewind();
         foreach (ch[i]) ch[i] = '0;
         pos_addr = pos_start;
         speed_cd = 1;
         speed_val = 1;
         line_cd = 1;
         noise = 0;
         env = 0;
         env_wr = 0;
      endfunction

      function void set_reg(bit [2:0] idx, bit [15:0] v);
         case (idx)
            REG_SAMPLES:   smp_base = v;
            REG_ORNAMENTS: orn_base = v;
            REG_PATTERNS:  pat_base = v;
            REG_POS_START: pos_start = v;
            REG_LOOP_POS:  loop_pos = v;
            default: ;
         endcase
      endfunction

      function bit [7:0] fetch8(int unsigned a);
         return mem[(a & 32'hFFFF) % MEM_DEPTH];
      endfunction

      function bit [15:0] fetch16(int unsigned a);
         return {fetch8(a + 1), fetch8(a)};
      endfunction

      function void apply_param(int c, inout bit [15:0] p, input bit [7:0] a);
         bit [7:0] k, b, v;
         k = a - 8'd1;
         p = p + 16'd1;
         if (ch[c].fresh) begin
            ch[c].pat_addr = p + 16'd1;
            ch[c].fresh = 0;
         end
         b = fetch8(p);
         case (k)
            K_VOL_SET: if (ch[c].vol_cmds) ch[c].vol = b & 8'd15;
            K_VOL_ADD: if (ch[c].vol_cmds) ch[c].vol = (ch[c].vol + b) & 8'd15;
            K_VOL_ALL: if (ch[c].vol_cmds) for (int i = 0; i < 3; i++) ch[i].vol = b;
            K_VOL_ALL_ADD: begin
               if (ch[c].vol_cmds)
                  for (int i = 0; i < 3; i++) ch[i].vol = (ch[i].vol + b) & 8'd15;
            end
            K_SPEED_SET, K_SPEED_ADD: begin
               if (ch[c].vol_cmds) begin
                  v = (k == K_SPEED_SET) ? (b & 8'd31) : ((speed_cd + b) & 8'd31);
                  if (v == 0) v = 8'd32;
                  speed_cd = v;
                  speed_val = v;
               end
            end
            K_GLIDE_DOWN, K_GLIDE_UP: begin
               ch[c].gl_off = 0;
               ch[c].glide = 1;
               ch[c].gl_step = (k == K_GLIDE_DOWN) ? 16'd0 - {8'd0, b} : {8'd0, b};
            end
            default: begin
               ch[c].env_on = 1;
               env = {k[3:0], b};
               env_wr = 1;
            end
         endcase
      endfunction

      function void pick_sample(int c, bit [7:0] a);
         ch[c].env_on = 0;
         ch[c].orn_on = 0;
         ch[c].glide = 0;
         ch[c].on = 1;
         ch[c].smp_start = fetch16(32'(a) * 2 + smp_base);
         ch[c].smp_pos = ch[c].smp_start + 16'd2;
         ch[c].smp_ticks = TICKS_INIT;
         ch[c].mix_noise = 1;
         ch[c].mix_tone = 1;
      endfunction

      function void pick_ornament(int c, bit [7:0] a);
         ch[c].orn_start = fetch16(32'(a) * 2 + orn_base);
         ch[c].orn_pos = ch[c].orn_start + 16'd2;
         ch[c].orn_ticks = TICKS_INIT;
         ch[c].orn_on = 1;
      endfunction

      function void finish_note(int c, inout bit [15:0] p);
         bit [7:0] op, s, o, x;
         op = fetch8(p);
         if (op <= OP_OFFP_MAX) begin
            apply_param(c, p, op);
         end else begin
            s = (op >> 1) & 8'd31;
            if (s != 0) pick_sample(c, s);
            if (op[6]) begin
               o = fetch8(32'(p) + 1) >> 4;
               if (op[0]) o = o | 8'd16;
               if (o != 0) pick_ornament(c, o);
               p = p + 16'd1;
               x = fetch8(p) & 8'd15;
               if (x != 0) apply_param(c, p, x);
            end
         end
         p = p + 16'd1;
      endfunction

      function void repeat_last(int c);
         bit [15:0] p;
         bit [7:0]  op;
         p = ch[c].cmd_addr;
         op = fetch8(p);
         ch[c].fresh = 0;
         if (op <= OP_OFFP_MAX) begin
            p = p + 16'd1;
            finish_note(c, p);
         end else begin
            pick_sample(c, op & 8'd31);
         end
      endfunction

      function void step_pattern(int c);
         bit [15:0] p;
         bit [7:0]  op;
         if (ch[c].rep != 0) begin
            ch[c].rep = ch[c].rep - 8'd1;
            if (ch[c].rep_active) repeat_last(c);
            return;
         end
         p = ch[c].pat_addr;
         ch[c].fresh = 1;
         ch[c].rep_active = 0;
         op = fetch8(p);
         if (op <= OP_NOTE_MAX) begin
            ch[c].note = op;
            ch[c].cmd_addr = p;
            p = p + 16'd1;
            finish_note(c, p);
            if (ch[c].fresh) ch[c].pat_addr = p;
         end else if (op <= OP_PARAM_MAX) begin
            apply_param(c, p, op - OP_PARAM_BASE);
         end else if (op <= OP_OFFP_MAX) begin
            ch[c].mix_noise = 0;
            ch[c].mix_tone = 0;
            ch[c].on = 0;
            if (op != OP_OFF) apply_param(c, p, op - OP_OFF);
            else ch[c].pat_addr = p + 16'd1;
         end else if (op <= OP_REP_MAX) begin
            ch[c].pat_addr = p + 16'd1;
            if (op <= OP_SHIFT_MAX) begin
               if (!op[4]) ch[c].note = ch[c].note + (op & 8'd15);
               else ch[c].note = ch[c].note - (op & 8'd15);
            end else begin
               ch[c].rep = op & 8'd15;
               if (!op[4]) return;
               if (ch[c].rep != 0) ch[c].rep_active = 1;
            end
            repeat_last(c);
         end else begin
            ch[c].pat_addr = p + 16'd1;
            ch[c].cmd_addr = p;
            pick_sample(c, op & 8'd31);
         end
      endfunction

      function bit [7:0] voice_output(int c, inout bit [7:0] mix);
         bit [7:0]  amp, b0, b1, j, hi, tr;
         bit [31:0] ton, delta;
         bit [15:0] src;
         mix = mix << 1;
         if (!ch[c].on) return 8'd0;
         b0 = fetch8(ch[c].smp_pos);
         amp = b0 & 8'd15;
         if (amp != 0) begin
            amp = amp - ch[c].vol;
            if (amp[7]) amp = 0;
         end else if (ch[c].env_on) begin
            amp = 8'd16;
         end
         b1 = fetch8(32'(ch[c].smp_pos) + 1);
         if (b1[5]) begin
            mix = mix | 8'd8;
            noise = {b0[7:4], 1'b0};
            if (b1[7]) noise = noise + 5'd1;
         end
         if (b1[6]) mix = mix | 8'd1;
         j = ch[c].note;
         if (ch[c].orn_on) begin
            j = j + fetch8(ch[c].orn_pos);
            ch[c].orn_ticks = ch[c].orn_ticks - 8'd1;
            if (ch[c].orn_ticks == 0) begin
               src = (fetch8(ch[c].orn_start) != LOOP_MARK) ? ch[c].orn_start
                                                           : ch[c].smp_start;
               ch[c].orn_ticks = fetch8(32'(src) + 1);
               ch[c].orn_pos = ch[c].orn_start + 16'd2 + {8'd0, fetch8(src)};
            end else begin
               ch[c].orn_pos = ch[c].orn_pos + 16'd1;
            end
         end
         hi = ch[c].transp & 8'd15;
         tr = (hi < TRANSPOSE_NEG) ? hi : 8'd8 - hi;
         j = j + tr;
         if (j > NOTE_MAX) j = NOTE_MAX;
         delta = {20'd0, b1[3:0], fetch8(32'(ch[c].smp_pos) + 2)};
         if (b1[4]) ton = 32'(NOTE_PERIOD[j]) + delta;
         else ton = 32'(NOTE_PERIOD[j]) - delta;
         ch[c].smp_ticks = ch[c].smp_ticks - 8'd1;
         if (ch[c].smp_ticks == 0) begin
            ch[c].smp_ticks = fetch8(32'(ch[c].smp_start) + 1);
            if (fetch8(ch[c].smp_start) == LOOP_MARK) begin
               ch[c].on = 0;
               ch[c].orn_on = 0;
            end
            ch[c].smp_pos = 16'(32'(ch[c].smp_start) + 2 + 3 * fetch8(ch[c].smp_start));
         end else begin
            ch[c].smp_pos = ch[c].smp_pos + 16'd3;
         end
         if (ch[c].glide) begin
            ton = ton + ch[c].gl_off;
            ch[c].gl_off = ch[c].gl_off + ch[c].gl_step;
         end
         ch[c].tone = {4'd0, ton[11:0]};
         return amp;
      endfunction

      function void read_position(int c, bit first);
         bit [7:0]  e;
         bit [15:0] pa;
         if (fetch8(pos_addr) == 0) pos_addr = loop_pos;
         e = fetch8(pos_addr);
         ch[c].vol_cmds = e[7];
         pa = fetch16(32'(pat_base) + {e[6:0], 1'b0});
         if (first) line_cd = fetch8(pa);
         ch[c].pat_addr = pa + 16'd1;
         pos_addr = pos_addr + 16'd1;
         e = fetch8(pos_addr);
         ch[c].vol = e & 8'd15;
         ch[c].transp = e >> 4;
         pos_addr = pos_addr + 16'd1;
         ch[c].rep = 0;
      endfunction

      // advance the player state by one accepted beat
      function void note_item(bit [1:0] act, bit [15:0] addr, bit [7:0] data);
         bit [7:0] mix;
         bit [7:0] amp [3];
         frame_t   f;
         case (act)
            ACT_WRITE:   mem[addr % MEM_DEPTH] = data;
            ACT_RESTART: rewind();
            ACT_TICK: begin
               mix = 0;
               env_wr = 0;
               speed_cd = speed_cd - 8'd1;
               if (speed_cd == 0) begin
                  speed_cd = speed_val;
                  line_cd = line_cd - 8'd1;
                  if (line_cd == 0) begin
                     read_position(2, 1);
                     read_position(1, 0);
                     read_position(0, 0);
                     speed_val = fetch8(pos_addr);
                     speed_cd = speed_val;
                     pos_addr = pos_addr + 16'd1;
                  end
                  for (int i = 2; i >= 0; i--) step_pattern(i);
               end
               for (int i = 2; i >= 0; i--) amp[i] = voice_output(i, mix);
               mix = ~mix & 8'h3F;
               if (!ch[0].mix_noise) mix = mix | 8'd8;
               if (!ch[0].mix_tone)  mix = mix | 8'd1;
               if (!ch[1].mix_noise) mix = mix | 8'd16;
               if (!ch[1].mix_tone)  mix = mix | 8'd2;
               if (!ch[2].mix_noise) mix = mix | 8'd32;
               if (!ch[2].mix_tone)  mix = mix | 8'd4;
               f.tone_a = ch[0].tone[11:0];
               f.tone_b = ch[1].tone[11:0];
               f.tone_c = ch[2].tone[11:0];
               f.noise = noise;
               f.mixer = mix[5:0];
               f.amp_a = amp[0][4:0];
               f.amp_b = amp[1][4:0];
               f.amp_c = amp[2][4:0];
               f.env_shape = env[11:8];
               f.env_fine = env[7:0];
               f.env_wr = env_wr;
               frames.push_back(f);
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task cmp(string field, int got, int want);
         if (got != want)
            report($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
      endtask

      task check_frame(frame_t got);
         frame_t want;
         if (frames.size() == 0) begin
            report("result beat with no tick pending");
            return;
         end
         want = frames.pop_front();
         cmp("tone_a", got.tone_a, want.tone_a);
         cmp("tone_b", got.tone_b, want.tone_b);
         cmp("tone_c", got.tone_c, want.tone_c);
         cmp("noise_period", got.noise, want.noise);
         cmp("mixer", got.mixer, want.mixer);
         cmp("amp_a", got.amp_a, want.amp_a);
         cmp("amp_b", got.amp_b, want.amp_b);
         cmp("amp_c", got.amp_c, want.amp_c);
         cmp("env_shape", got.env_shape, want.env_shape);
         cmp("env_period_fine", got.env_fine, want.env_fine);
         cmp("env_shape_written", got.env_wr, want.env_wr);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_action = ACT_WRITE;
   logic [15:0] req_mem_addr = 0;
   logic [7:0]  req_mem_byte = 0;
   logic        rsp_valid;
   logic [11:0] rsp_tone_a, rsp_tone_b, rsp_tone_c;
   logic [4:0]  rsp_noise_period;
   logic [5:0]  rsp_mixer;
   logic [4:0]  rsp_amp_a, rsp_amp_b, rsp_amp_c;
   logic [3:0]  rsp_env_shape;
   logic [7:0]  rsp_env_period_fine;
   logic        rsp_env_shape_written;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [4:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   tick_scoreboard sb = new();
   frame_t seen;
   int cycles = 0;

   tracker_pattern_tick_player i_dut (
      .clock, .reset, .start, .busy,
      .req_action, .req_mem_addr, .req_mem_byte,
      .rsp_valid, .rsp_tone_a, .rsp_tone_b, .rsp_tone_c, .rsp_noise_period,
      .rsp_mixer, .rsp_amp_a, .rsp_amp_b, .rsp_amp_c, .rsp_env_shape,
      .rsp_env_period_fine, .rsp_env_shape_written,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen.tone_a = rsp_tone_a;
         seen.tone_b = rsp_tone_b;
         seen.tone_c = rsp_tone_c;
         seen.noise = rsp_noise_period;
         seen.mixer = rsp_mixer;
         seen.amp_a = rsp_amp_a;
         seen.amp_b = rsp_amp_b;
         seen.amp_c = rsp_amp_c;
         seen.env_shape = rsp_env_shape;
         seen.env_fine = rsp_env_period_fine;
         seen.env_wr = rsp_env_shape_written;
         sb.check_frame(seen);
      end
   end

   // present one beat and hold it until the block takes it
   task automatic send(input bit [1:0] act, input bit [15:0] addr, input bit [7:0] data);
      start <= 1;
      req_action <= act;
      req_mem_addr <= addr;
      req_mem_byte <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(act, addr, data);
   endtask

   task automatic put(input bit [15:0] addr, input bit [7:0] data);
      send(ACT_WRITE, addr, data);
   endtask

   task automatic put16(input bit [15:0] addr, input bit [15:0] data);
      put(addr, data[7:0]);
      put(addr + 16'd1, data[15:8]);
   endtask

   task automatic idle(input int n);
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // drop start, drain all pending ticks, then let a trailing write finish
   task automatic settle();
      start <= 0;
      @(posedge clock);
      while (sb.frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input bit [2:0] idx, input bit [15:0] val);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= {idx, 2'b00};
      pwdata <= {16'd0, val};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic bit [7:0] pattern_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return 8'($urandom_range(0, OP_NOTE_MAX));
      if (r < 55) return 8'($urandom_range(8'hC0, 8'hFF));
      if (r < 65) return 8'($urandom_range(OP_PARAM_BASE, OP_PARAM_MAX));
      if (r < 72) return 8'($urandom_range(OP_OFF, OP_OFFP_MAX));
      if (r < 87) return 8'($urandom_range(8'h80, OP_REP_MAX));
      return 8'($urandom_range(0, 15));
   endfunction

   // lay out tables, patterns, samples, ornaments and positions from base b
   task automatic load_song(input bit [15:0] b);
      bit [15:0] smp_tab, orn_tab, pat_tab, pats, smps, orns, pos, lp;
      int k, i;
      smp_tab = b;
      orn_tab = b + 16'd64;
      pat_tab = b + 16'd128;
      pats = b + 16'd384;
      smps = b + 16'd704;
      orns = b + 16'd912;
      pos = b + 16'd1008;
      lp = pos + 16'(7 * $urandom_range(0, 5));
      settle();
      csr_write(REG_SAMPLES, smp_tab);
      csr_write(REG_ORNAMENTS, orn_tab);
      csr_write(REG_PATTERNS, pat_tab);
      csr_write(REG_POS_START, pos);
      csr_write(REG_LOOP_POS, lp);
      for (k = 0; k < 32; k++) begin
         put16(smp_tab + 2 * k, smps + 26 * (k % 8));
         put16(orn_tab + 2 * k, orns + 12 * (k % 8));
      end
      for (k = 0; k < 128; k++) put16(pat_tab + 2 * k, pats + 40 * (k % 8));
      for (k = 0; k < 8; k++) begin
         put(pats + 40 * k, ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4));
         for (i = 1; i < 40; i++) put(pats + 40 * k + i, pattern_byte());
         put(smps + 26 * k, ($urandom_range(0, 7) == 0) ? LOOP_MARK : $urandom_range(0, 3));
         put(smps + 26 * k + 1, $urandom_range(1, 8));
         for (i = 2; i < 26; i++) put(smps + 26 * k + i, $urandom);
         put(orns + 12 * k, ($urandom_range(0, 7) == 0) ? LOOP_MARK : $urandom_range(0, 3));
         put(orns + 12 * k + 1, $urandom_range(1, 8));
         for (i = 2; i < 12; i++)
            put(orns + 12 * k + i, ($urandom_range(0, 9) == 0) ? $urandom
                                                              : $urandom_range(0, 12));
      end
      for (k = 0; k < 6; k++) begin
         for (i = 0; i < 3; i++) begin
            put(pos + 7 * k + 2 * i, $urandom_range(1, 255));
            put(pos + 7 * k + 2 * i + 1, $urandom);
         end
         put(pos + 7 * k + 6, ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3));
      end
      put(pos + 16'd42, 8'd0);
      send(ACT_RESTART, 16'($urandom), 8'($urandom));
   endtask

   initial begin
      bit [15:0] base;
      int burst, r;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // every byte gets written, so no read ever hits an unwritten entry
      for (int a = 0; a < MEM_DEPTH; a++) put(a[15:0], 8'($urandom));

      for (int phase = 0; phase < 5; phase++) begin
         base = (phase == 0) ? 16'h0000 : (phase == 1) ? 16'hFFFF : 16'($urandom);
         load_song(base);
         if (phase == 0) begin
            put(16'h0000, 8'h00);
            put(16'hFFFF, 8'hFF);
            send(ACT_UNUSED, 16'hAAAA, 8'h55);
            for (int t = 0; t < 8; t++) send(ACT_TICK, 16'h5555, 8'hAA);
            send(ACT_UNUSED, 16'h5555, 8'hAA);
            send(ACT_RESTART, 16'hFFFF, 8'hFF);
            for (int t = 0; t < 10; t++) send(ACT_TICK, 16'h0000, 8'h00);
         end
         burst = 0;
         for (int n = 0; n < 120; n++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
               // the third song runs back to back with no gaps at all
               if (phase != 2)
                  idle($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 250));
            end
            burst--;
            r = $urandom_range(0, 99);
            if (r < 84) send(ACT_TICK, 16'($urandom), 8'($urandom));
            else if (r < 92) put(16'($urandom), 8'($urandom));
            else if (r < 96) send(ACT_RESTART, 16'($urandom), 8'($urandom));
            else if (r < 98) send(ACT_UNUSED, 16'($urandom), 8'($urandom));
            else send(ACT_TICK, 16'($urandom), 8'($urandom));
         end
      end

      settle();
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
